>>> src/rti_pkg.sv
// Package for the ray/triangle hit test: widths, register indexes, reset values.
// No dependencies.
package rti_pkg;
  localparam int COORD_WIDTH_DEF = 16;
  localparam int TOL_WIDTH = 16;
  localparam int CFG_IDX_WIDTH = 3;
  localparam int DIST_SHIFT = 20;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_ORG_X = 3'd0,
    REG_ORG_Y = 3'd1,
    REG_ORG_Z = 3'd2,
    REG_DIR_X = 3'd3,
    REG_DIR_Y = 3'd4,
    REG_DIR_Z = 3'd5,
    REG_PAR_TOL = 3'd6,
    REG_HIT_TOL = 3'd7
  } cfg_idx_t;

  localparam logic [TOL_WIDTH-1:0] PAR_TOL_RST = 16'd168;
  localparam logic [TOL_WIDTH-1:0] HIT_TOL_RST = 16'd10;
  localparam int DIR_Z_RST = 256;
endpackage

>>> src/rti_cfg_regs.sv
// Ray and tolerance configuration registers.
// Depends on rti_pkg.
module rti_cfg_regs #(
  parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic [rti_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [31:0]                       cfg_data,
  output logic signed [COORD_WIDTH-1:0]     org_x,
  output logic signed [COORD_WIDTH-1:0]     org_y,
  output logic signed [COORD_WIDTH-1:0]     org_z,
  output logic signed [COORD_WIDTH-1:0]     dir_x,
  output logic signed [COORD_WIDTH-1:0]     dir_y,
  output logic signed [COORD_WIDTH-1:0]     dir_z,
  output logic [rti_pkg::TOL_WIDTH-1:0]     par_tol,
  output logic [rti_pkg::TOL_WIDTH-1:0]     hit_tol
);
  import rti_pkg::*;

  logic signed [COORD_WIDTH-1:0] ox_r, oy_r, oz_r, dx_r, dy_r, dz_r;
  logic [TOL_WIDTH-1:0] pt_r, ht_r;
  logic [COORD_WIDTH-1:0] c_val;

  assign c_val = cfg_data[COORD_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ox_r <= '0;
      oy_r <= '0;
      oz_r <= '0;
      dx_r <= '0;
      dy_r <= '0;
      dz_r <= COORD_WIDTH'(DIR_Z_RST);
      pt_r <= PAR_TOL_RST;
      ht_r <= HIT_TOL_RST;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        REG_ORG_X: ox_r <= c_val;
        REG_ORG_Y: oy_r <= c_val;
        REG_ORG_Z: oz_r <= c_val;
        REG_DIR_X: dx_r <= c_val;
        REG_DIR_Y: dy_r <= c_val;
        REG_DIR_Z: dz_r <= c_val;
        REG_PAR_TOL: pt_r <= cfg_data[TOL_WIDTH-1:0];
        REG_HIT_TOL: ht_r <= cfg_data[TOL_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign org_x = ox_r;
  assign org_y = oy_r;
  assign org_z = oz_r;
  assign dir_x = dx_r;
  assign dir_y = dy_r;
  assign dir_z = dz_r;
  assign par_tol = pt_r;
  assign hit_tol = ht_r;
endmodule

>>> src/rti_pipe.sv
// Six-stage Moller-Trumbore datapath with stall-hold valid bits.
// Depends on rti_pkg.
module rti_pipe #(
  parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_req,
  input  logic signed [COORD_WIDTH-1:0] v0x, v0y, v0z, v1x, v1y, v1z, v2x, v2y, v2z,
  input  logic signed [COORD_WIDTH-1:0] px, py, pz, dx, dy, dz,
  input  logic [rti_pkg::TOL_WIDTH-1:0] par_tol,
  input  logic [rti_pkg::TOL_WIDTH-1:0] hit_tol,
  output logic                          out_req,
  output logic                          out_hit
);
  import rti_pkg::*;

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW + 1;
  localparam int SW = 3 * DW + 3;
  localparam int LW = SW + DIST_SHIFT;
  localparam int NST = 6;

  logic [NST-1:0] vld_r;

  logic signed [DW-1:0] e1x_r, e1y_r, e1z_r, e2x_r, e2y_r, e2z_r, sx_r, sy_r, sz_r;
  logic signed [PW-1:0] hx_r, hy_r, hz_r, qx_r, qy_r, qz_r;
  logic signed [DW-1:0] e1x2_r, e1y2_r, e1z2_r, e2x2_r, e2y2_r, e2z2_r;
  logic signed [DW-1:0] sx2_r, sy2_r, sz2_r;
  logic signed [SW-1:0] det_r, un_r, wn_r, tn_r;
  logic signed [SW-1:0] mag_r, u4_r, w4_r, t4_r;
  logic par4_r;
  logic ok5_r, par5_r;
  logic [SW-1:0] t5_r;
  logic [LW-1:0] rhs5_r;
  logic hit_r;

  function automatic logic signed [DW-1:0] dif(input logic signed [COORD_WIDTH-1:0] a,
                                               input logic signed [COORD_WIDTH-1:0] b);
    return DW'(a) - DW'(b);
  endfunction

  function automatic logic signed [PW-1:0] crs(input logic signed [DW-1:0] a,
                                               input logic signed [DW-1:0] b,
                                               input logic signed [DW-1:0] c,
                                               input logic signed [DW-1:0] d);
    return PW'(a * b) - PW'(c * d);
  endfunction

  function automatic logic signed [SW-1:0] dot(input logic signed [DW-1:0] a0,
                                               input logic signed [DW-1:0] a1,
                                               input logic signed [DW-1:0] a2,
                                               input logic signed [PW-1:0] b0,
                                               input logic signed [PW-1:0] b1,
                                               input logic signed [PW-1:0] b2);
    return SW'(a0 * b0) + SW'(a1 * b1) + SW'(a2 * b2);
  endfunction

  logic signed [DW-1:0] dxe, dye, dze;
  assign dxe = DW'(dx);
  assign dye = DW'(dy);
  assign dze = DW'(dz);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_req};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e1x_r <= dif(v1x, v0x);
      e1y_r <= dif(v1y, v0y);
      e1z_r <= dif(v1z, v0z);
      e2x_r <= dif(v2x, v0x);
      e2y_r <= dif(v2y, v0y);
      e2z_r <= dif(v2z, v0z);
      sx_r <= dif(px, v0x);
      sy_r <= dif(py, v0y);
      sz_r <= dif(pz, v0z);

      hx_r <= crs(dye, e2z_r, e2y_r, dze);
      hy_r <= crs(dze, e2x_r, e2z_r, dxe);
      hz_r <= crs(dxe, e2y_r, e2x_r, dye);
      qx_r <= crs(sy_r, e1z_r, e1y_r, sz_r);
      qy_r <= crs(sz_r, e1x_r, e1z_r, sx_r);
      qz_r <= crs(sx_r, e1y_r, e1x_r, sy_r);
      e1x2_r <= e1x_r;
      e1y2_r <= e1y_r;
      e1z2_r <= e1z_r;
      e2x2_r <= e2x_r;
      e2y2_r <= e2y_r;
      e2z2_r <= e2z_r;
      sx2_r <= sx_r;
      sy2_r <= sy_r;
      sz2_r <= sz_r;

      det_r <= dot(e1x2_r, e1y2_r, e1z2_r, hx_r, hy_r, hz_r);
      un_r <= dot(sx2_r, sy2_r, sz2_r, hx_r, hy_r, hz_r);
      wn_r <= dot(dxe, dye, dze, qx_r, qy_r, qz_r);
      tn_r <= dot(e2x2_r, e2y2_r, e2z2_r, qx_r, qy_r, qz_r);

      mag_r <= det_r[SW-1] ? -det_r : det_r;
      u4_r <= det_r[SW-1] ? -un_r : un_r;
      w4_r <= det_r[SW-1] ? -wn_r : wn_r;
      t4_r <= det_r[SW-1] ? -tn_r : tn_r;
      par4_r <= (det_r[SW-1] ? -det_r : det_r) <= $signed({1'b0, par_tol});

      par5_r <= par4_r;
      ok5_r <= !u4_r[SW-1] && (u4_r <= mag_r) && !w4_r[SW-1] && ((u4_r + w4_r) <= mag_r)
               && !t4_r[SW-1] && (t4_r != '0);
      t5_r <= t4_r;
      rhs5_r <= LW'(mag_r) * LW'(hit_tol);

      hit_r <= !par5_r && ok5_r && ({t5_r, DIST_SHIFT'(0)} > rhs5_r);
    end
  end

  assign out_req = vld_r[NST-1];
  assign out_hit = hit_r;

  a_par_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && vld_r[4] && par5_r) |=> (out_req && !out_hit))
    else $error("parallel triangle reported as hit");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("valid bits moved during stall");
  a_mag: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[3] |-> !mag_r[SW-1])
    else $error("negative determinant magnitude");
endmodule

>>> src/ray_triangle_intersection_test.sv
// Ray/triangle hit test, Moller-Trumbore in exact fixed point.
// Throughput: one triangle per cycle while the output is not stalled.
// The six-stage datapath advances whenever its output register is empty or taken.
// Reset (rst_n low, synchronous) empties the pipeline and loads register defaults.
// Depends on rti_pkg, rti_cfg_regs, rti_pipe.
module ray_triangle_intersection_test #(
  parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [COORD_WIDTH-1:0]     in_v0_x, in_v0_y, in_v0_z,
  input  logic signed [COORD_WIDTH-1:0]     in_v1_x, in_v1_y, in_v1_z,
  input  logic signed [COORD_WIDTH-1:0]     in_v2_x, in_v2_y, in_v2_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_hit,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rti_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [31:0]                       cfg_data
);
  import rti_pkg::*;

  logic signed [COORD_WIDTH-1:0] px, py, pz, dx, dy, dz;
  logic [TOL_WIDTH-1:0] par_tol, hit_tol;
  logic adv;

  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign cfg_ready = 1'b1;

  rti_cfg_regs #(.COORD_WIDTH(COORD_WIDTH)) u_cfg (
    .clk, .rst_n, .cfg_valid, .cfg_index, .cfg_data,
    .org_x(px), .org_y(py), .org_z(pz), .dir_x(dx), .dir_y(dy), .dir_z(dz),
    .par_tol, .hit_tol
  );

  rti_pipe #(.COORD_WIDTH(COORD_WIDTH)) u_pipe (
    .clk, .rst_n, .adv, .in_req(in_valid),
    .v0x(in_v0_x), .v0y(in_v0_y), .v0z(in_v0_z),
    .v1x(in_v1_x), .v1y(in_v1_y), .v1z(in_v1_z),
    .v2x(in_v2_x), .v2y(in_v2_y), .v2z(in_v2_z),
    .px, .py, .pz, .dx, .dy, .dz, .par_tol, .hit_tol,
    .out_req(out_valid), .out_hit
  );
endmodule

>>> tb/ray_triangle_intersection_test_tb.sv
// Testbench for ray_triangle_intersection_test: directed and random triangles against
// an exact integer hit predictor, with random idling on both channels.
// Depends on rti_pkg and the ray_triangle_intersection_test RTL.
module ray_triangle_intersection_test_tb;
  import rti_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef logic signed [CW-1:0] coord_t;
  typedef struct {
    coord_t c[9];
  } tri_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  coord_t in_v0_x = '0, in_v0_y = '0, in_v0_z = '0;
  coord_t in_v1_x = '0, in_v1_y = '0, in_v1_z = '0;
  coord_t in_v2_x = '0, in_v2_y = '0, in_v2_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_hit;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  coord_t ray_org[3];
  coord_t ray_dir[3];
  logic [TOL_WIDTH-1:0] par_tol, hit_tol;

  logic hit_queue[$];
  int send_idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int idle_cycles = 0;

  ray_triangle_intersection_test DUT (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ray_triangle_intersection_test verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic logic predict_hit(tri_t t);
    longint px, py, pz, dx, dy, dz, e1x, e1y, e1z, e2x, e2y, e2z, sx, sy, sz;
    longint hx, hy, hz, det, mag, qx, qy, qz, un, wn, tn;
    logic [127:0] lhs, rhs;
    px = ray_org[0]; py = ray_org[1]; pz = ray_org[2];
    dx = ray_dir[0]; dy = ray_dir[1]; dz = ray_dir[2];
    e1x = t.c[3] - t.c[0]; e1y = t.c[4] - t.c[1]; e1z = t.c[5] - t.c[2];
    e2x = t.c[6] - t.c[0]; e2y = t.c[7] - t.c[1]; e2z = t.c[8] - t.c[2];
    sx = px - t.c[0]; sy = py - t.c[1]; sz = pz - t.c[2];
    hx = dy * e2z - e2y * dz;
    hy = dz * e2x - e2z * dx;
    hz = dx * e2y - e2x * dy;
    det = e1x * hx + e1y * hy + e1z * hz;
    mag = det < 0 ? -det : det;
    if (mag <= longint'(par_tol)) return 1'b0;
    un = sx * hx + sy * hy + sz * hz;
    qx = sy * e1z - e1y * sz;
    qy = sz * e1x - e1z * sx;
    qz = sx * e1y - e1x * sy;
    wn = dx * qx + dy * qy + dz * qz;
    tn = e2x * qx + e2y * qy + e2z * qz;
    if (det < 0) begin
      un = -un; wn = -wn; tn = -tn;
    end
    if (un < 0 || un > mag) return 1'b0;
    if (wn < 0 || un + wn > mag) return 1'b0;
    if (tn <= 0) return 1'b0;
    lhs = 128'(tn) << DIST_SHIFT;
    rhs = 128'(mag) * 128'(hit_tol);
    return lhs > rhs;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (hit_queue.size() == 0) begin
        $display("%0t: unexpected result hit=%0b", $time, out_hit);
        errors++;
      end else begin
        if (out_hit !== hit_queue[0]) begin
          $display("%0t: hit mismatch expected %0b actual %0b", $time, hit_queue[0], out_hit);
          errors++;
        end
        void'(hit_queue.pop_front());
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_ORG_X: ray_org[0] = value[CW-1:0];
      REG_ORG_Y: ray_org[1] = value[CW-1:0];
      REG_ORG_Z: ray_org[2] = value[CW-1:0];
      REG_DIR_X: ray_dir[0] = value[CW-1:0];
      REG_DIR_Y: ray_dir[1] = value[CW-1:0];
      REG_DIR_Z: ray_dir[2] = value[CW-1:0];
      REG_PAR_TOL: par_tol = value[TOL_WIDTH-1:0];
      REG_HIT_TOL: hit_tol = value[TOL_WIDTH-1:0];
      default: ;
    endcase
  endtask

  task automatic set_ray(int ox, int oy, int oz, int dx, int dy, int dz, int pt, int ht);
    write_reg(REG_ORG_X, ox);
    write_reg(REG_ORG_Y, oy);
    write_reg(REG_ORG_Z, oz);
    write_reg(REG_DIR_X, dx);
    write_reg(REG_DIR_Y, dy);
    write_reg(REG_DIR_Z, dz);
    write_reg(REG_PAR_TOL, pt);
    write_reg(REG_HIT_TOL, ht);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_triangle(tri_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_v0_x, in_v0_y, in_v0_z} <= {t.c[0], t.c[1], t.c[2]};
    {in_v1_x, in_v1_y, in_v1_z} <= {t.c[3], t.c[4], t.c[5]};
    {in_v2_x, in_v2_y, in_v2_z} <= {t.c[6], t.c[7], t.c[8]};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    hit_queue.push_back(predict_hit(t));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (hit_queue.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic coord_t rand_coord(int span);
    if (span == 0) return coord_t'($urandom);
    return coord_t'($urandom_range(2 * span) - span);
  endfunction

  // triangle at a random point along the ray, vertices offset randomly within span (fully random if span is 0)
  function automatic tri_t aimed_triangle(int span);
    tri_t t;
    longint along;
    along = $urandom_range(2048);
    for (int v = 0; v < 3; v++)
      for (int a = 0; a < 3; a++)
        t.c[3*v+a] = coord_t'(ray_org[a] + ((ray_dir[a] * along) >>> 8) + rand_coord(span));
    return t;
  endfunction

  task automatic test_directed;
    tri_t t;
    coord_t ext[4] = '{coord_t'(-32768), coord_t'(32767), coord_t'(0), coord_t'(-1)};
    set_ray(0, 0, 0, 0, 0, 256, int'(PAR_TOL_RST), int'(HIT_TOL_RST));
    t.c = '{-256, -256, 512, 512, -256, 512, -256, 512, 512};
    send_triangle(t);
    t.c = '{-256, -256, -512, 512, -256, -512, -256, 512, -512};
    send_triangle(t);
    t.c = '{256, 256, 512, 512, 256, 512, 256, 512, 512};
    send_triangle(t);
    t.c = '{0, 0, 512, 0, 0, 512, 0, 0, 512};
    send_triangle(t);
    t.c = '{0, 0, 0, 256, 0, 0, 0, 256, 0};
    send_triangle(t);
    t.c = '{0, 0, 256, 0, 0, 512, 0, 0, 768};
    send_triangle(t);
    t.c = '{0, 0, 512, 256, 0, 512, 0, 256, 512};
    send_triangle(t);
    for (int i = 0; i < 12; i++) begin
      foreach (t.c[k]) t.c[k] = ext[(i + k * (i / 4 + 1)) % 4];
      send_triangle(t);
    end
    drain();
    set_ray(0, 0, 0, 0, 0, 0, 0, 0);
    t.c = '{-256, -256, 512, 512, -256, 512, -256, 512, 512};
    send_triangle(t);
    drain();
    set_ray(-32768, 32767, -32768, 32767, -32768, 32767, 65535, 65535);
    t.c = '{32767, -32768, 32767, -32768, 32767, -32768, 0, 0, 0};
    send_triangle(t);
    t.c = '{32767, 32767, 32767, -32768, -32768, -32768, 0, 32767, -32768};
    send_triangle(t);
    drain();
  endtask

  task automatic test_random_phase(int n, int idle, int stall);
    tri_t t;
    int span;
    send_idle_pct = idle;
    stall_pct = stall;
    set_ray(int'(rand_coord(2048)), int'(rand_coord(2048)), int'(rand_coord(2048)),
            int'(rand_coord(512)), int'(rand_coord(512)), int'(rand_coord(512)),
            $urandom_range(3) == 0 ? $urandom : $urandom_range(400),
            $urandom_range(3) == 0 ? $urandom : $urandom_range(40));
    for (int i = 0; i < n; i++) begin
      span = ($urandom_range(3) == 0) ? 0 : (1 << $urandom_range(12, 6));
      if ($urandom_range(9) < 7) t = aimed_triangle(span);
      else foreach (t.c[k]) t.c[k] = rand_coord(0);
      send_triangle(t);
    end
    drain();
  endtask

  task automatic test_pause_until_empty;
    tri_t t;
    send_idle_pct = 0;
    stall_pct = 30;
    for (int i = 0; i < 20; i++) begin
      t = aimed_triangle(256);
      send_triangle(t);
    end
    in_valid <= 1'b0;
    while (hit_queue.size() != 0) @(posedge clk);
    for (int i = 0; i < 20; i++) begin
      t = aimed_triangle(256);
      send_triangle(t);
    end
    drain();
  endtask

  initial begin
    ray_org = '{0, 0, 0};
    ray_dir = '{0, 0, coord_t'(DIR_Z_RST)};
    par_tol = PAR_TOL_RST;
    hit_tol = HIT_TOL_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    for (int p = 0; p < 16; p++) begin
      case (p % 4)
        0: test_random_phase(85, 0, 0);
        1: test_random_phase(85, 58, 0);
        2: test_random_phase(85, 0, 58);
        default: test_random_phase(85, 21, 21);
      endcase
    end
    test_pause_until_empty();
    if (errors == 0)
      $display("ray_triangle_intersection_test verification clean");
    else
      $display("ray_triangle_intersection_test verification failed");
    $finish;
  end
endmodule

>>> ray_triangle_intersection_test.f
src/rti_pkg.sv
src/rti_cfg_regs.sv
src/rti_pipe.sv
src/ray_triangle_intersection_test.sv
tb/ray_triangle_intersection_test_tb.sv
